// File: design/assert_macros.svh
// Assertion macros shared by the arbiter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define PSVA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Condition that must never hold at a clock edge outside reset.
`define PSVA_ASSERT_NEVER(name, clk, rst, cond) \
   `PSVA_ASSERT(name, clk, rst, !(cond))

`endif

// File: design/psva_pkg.sv
// Types, codes and reset constants for the priority sound voice arbiter.
package psva_pkg;

   localparam int NUM_VOICES_DEFAULT  = 3;
   localparam int NUM_EFFECTS_DEFAULT = 7;

   localparam int PRIO_W     = 3;
   localparam int PRIO_SLOTS = 7;
   localparam int TABLE_W    = PRIO_W * PRIO_SLOTS;
   localparam int HOLD_W     = 16;
   localparam int CSR_DATA_W = TABLE_W;
   localparam int CSR_IDX_W  = 2;

   // commands
   localparam logic [1:0] CMD_PLAY = 2'd0;
   localparam logic [1:0] CMD_ONCE = 2'd1;
   localparam logic [1:0] CMD_DONE = 2'd2;
   localparam logic [1:0] CMD_STOP = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD  = 2'd2;

   localparam logic               MODE_SINGLE = 1'b0;
   localparam logic               MODE_RESET  = 1'b1;
   localparam logic [TABLE_W-1:0] TABLE_RESET = 21'd611940;
   localparam logic [HOLD_W-1:0]  HOLD_RESET  = 16'd300;

   // stored priority: -1 means nothing playing
   typedef logic signed [PRIO_W:0] prio_type;
   localparam prio_type PRIO_NONE = -4'sd1;

   typedef struct packed {
      logic               mode_select;
      logic [TABLE_W-1:0] priority_table;
      logic [HOLD_W-1:0]  hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  sound_id;
      logic [31:0] now_ms;
      logic [2:0]  voice_busy;
      logic        sample_busy;
   } req_type;

   typedef struct packed {
      logic       start_sample;
      logic       start_voice;
      logic [1:0] voice_index;
      logic [2:0] effect_id;
      logic       stop_all;
   } rsp_type;

endpackage

// File: design/priority_sound_voice_arbiter_unit.sv
// Top level of the priority sound voice arbiter.
// One request in, one result out, a new request every cycle while
// req_stall is low. A request is captured in an input register; once the
// result register is free, a single decision pass (once-flag check,
// priority lookup, wrapping hold-time compare, voice search over all
// NUM_VOICES voices) updates the arbitration state and loads the result
// register. One transfer per cycle while the result is not stalled,
// set by that one pass between the two registers. A stalled result holds
// the result register; the input register still takes one more request,
// and req_stall rises only when both are full. Configuration writes are
// always ready and take effect on the next cycle; write only when idle.
// Priorities: sample channel and each voice store -1 after reset, and the
// sample channel again after a stop in single mode.
`include "assert_macros.svh"

module priority_sound_voice_arbiter_unit #(
   parameter int NUM_VOICES  = psva_pkg::NUM_VOICES_DEFAULT,
   parameter int NUM_EFFECTS = psva_pkg::NUM_EFFECTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  psva_pkg::req_type               req,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output psva_pkg::rsp_type               rsp,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psva_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psva_pkg::CSR_DATA_W-1:0] csr_data
);

   psva_pkg::cfg_type cfg;
   psva_pkg::req_type s1_item_ff;
   logic              s1_valid_ff, s1_valid_in;
   psva_pkg::rsp_type rsp_ff, decision;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              advance;
   logic              accept;

   psva_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   psva_engine #(
      .NUM_VOICES  (NUM_VOICES),
      .NUM_EFFECTS (NUM_EFFECTS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (decision)
   );

   // result register empty, or being drained by this transfer
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      if (accept)       s1_valid_in = 1'b1;
      else if (advance) s1_valid_in = 1'b0;
      else              s1_valid_in = s1_valid_ff;

      if (advance)       rsp_valid_in = 1'b1;
      else if (out_free) rsp_valid_in = 1'b0;
      else               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (accept)  s1_item_ff <= req;
      if (advance) rsp_ff     <= decision;
   end

   // a decided request always shows up as a result
   `PSVA_ASSERT(a_advance_result, clock, reset, advance |=> rsp_valid_ff)
   // a request waiting in the input register is never lost
   `PSVA_ASSERT(a_s1_kept, clock, reset,
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_item_ff)))

endmodule

// File: design/psva_csr.sv
// Configuration registers of the arbiter.
module psva_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psva_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psva_pkg::CSR_DATA_W-1:0]  csr_data,
   output psva_pkg::cfg_type                cfg
);

   psva_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            psva_pkg::CSR_MODE:  cfg_in.mode_select    = csr_data[0];
            psva_pkg::CSR_TABLE: cfg_in.priority_table = csr_data;
            psva_pkg::CSR_HOLD:  cfg_in.hold_ms        = csr_data[psva_pkg::HOLD_W-1:0];
            default: ;  // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_select    <= psva_pkg::MODE_RESET;
         cfg_ff.priority_table <= psva_pkg::TABLE_RESET;
         cfg_ff.hold_ms        <= psva_pkg::HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/psva_engine.sv
// Arbitration state and the single-pass decision for one request.
`include "assert_macros.svh"

module psva_engine #(
   parameter int NUM_VOICES  = psva_pkg::NUM_VOICES_DEFAULT,
   parameter int NUM_EFFECTS = psva_pkg::NUM_EFFECTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  psva_pkg::req_type item,
   input  psva_pkg::cfg_type cfg,
   output psva_pkg::rsp_type result
);

   localparam int VIW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   psva_pkg::prio_type         sample_prio_ff, sample_prio_in;
   logic [31:0]                sample_start_ff, sample_start_in;
   psva_pkg::prio_type         voice_prio_ff [NUM_VOICES];
   psva_pkg::prio_type         voice_prio_in [NUM_VOICES];
   logic [NUM_EFFECTS-1:0]     once_ff, once_in;

   logic [NUM_EFFECTS-1:0]     sel;
   logic                       id_ok;
   logic                       once_hit;
   logic [psva_pkg::PRIO_W-1:0] req_p;
   psva_pkg::prio_type         req_ps;
   logic [NUM_VOICES-1:0]      busy;
   logic                       any_idle;
   logic [VIW-1:0]             idle_idx;
   logic [VIW-1:0]             worst_idx;
   psva_pkg::prio_type         worst_p;
   logic [31:0]                elapsed;
   logic                       held;
   logic                       play;
   logic                       take_voice;
   logic [VIW-1:0]             slot;

   always_comb begin
      id_ok = (32'(item.sound_id) < NUM_EFFECTS);
      for (int e = 0; e < NUM_EFFECTS; e++) begin
         sel[e] = (32'(item.sound_id) == e);
      end
      once_hit = |(once_ff & sel);

      // effects past the table have priority 0
      req_p = '0;
      for (int j = 0; j < psva_pkg::PRIO_SLOTS; j++) begin
         if (32'(item.sound_id) == j) begin
            req_p = cfg.priority_table[j*psva_pkg::PRIO_W +: psva_pkg::PRIO_W];
         end
      end
      req_ps = psva_pkg::prio_type'({1'b0, req_p});
   end

   // voice search: first idle voice, else lowest priority (first on tie)
   always_comb begin
      busy     = NUM_VOICES'(item.voice_busy);
      any_idle = 1'b0;
      idle_idx = '0;
      for (int v = NUM_VOICES - 1; v >= 0; v--) begin
         if (!busy[v]) begin
            any_idle = 1'b1;
            idle_idx = VIW'(v);
         end
      end
      worst_p   = voice_prio_ff[0];
      worst_idx = '0;
      for (int v = 1; v < NUM_VOICES; v++) begin
         if (voice_prio_ff[v] < worst_p) begin
            worst_p   = voice_prio_ff[v];
            worst_idx = VIW'(v);
         end
      end
      take_voice = any_idle || (worst_p < req_ps);
      slot       = any_idle ? idle_idx : worst_idx;
   end

   // hold window, wrapping difference
   always_comb begin
      elapsed = item.now_ms - sample_start_ff;
      held    = item.sample_busy && (req_ps < sample_prio_ff) &&
                (elapsed < 32'(cfg.hold_ms));
   end

   always_comb begin
      result          = '0;
      sample_prio_in  = sample_prio_ff;
      sample_start_in = sample_start_ff;
      voice_prio_in   = voice_prio_ff;
      once_in         = once_ff;
      play            = 1'b0;

      case (item.command)
         psva_pkg::CMD_PLAY: play = id_ok;
         psva_pkg::CMD_ONCE: begin
            if (id_ok && !once_hit) begin
               once_in = once_ff | sel;
               play    = 1'b1;
            end
         end
         psva_pkg::CMD_DONE: begin
            if (id_ok) once_in = once_ff & ~sel;
         end
         default: begin
            if (cfg.mode_select == psva_pkg::MODE_SINGLE) sample_prio_in = psva_pkg::PRIO_NONE;
            result.stop_all = 1'b1;
         end
      endcase

      if (play) begin
         if (cfg.mode_select == psva_pkg::MODE_SINGLE) begin
            if (!held) begin
               sample_prio_in      = req_ps;
               sample_start_in     = item.now_ms;
               result.start_sample = 1'b1;
               result.effect_id    = item.sound_id;
            end
         end else if (take_voice) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
               if (slot == VIW'(v)) voice_prio_in[v] = req_ps;
            end
            result.start_voice = 1'b1;
            result.voice_index = 2'(slot);
            result.effect_id   = item.sound_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_prio_ff  <= psva_pkg::PRIO_NONE;
         sample_start_ff <= '0;
         once_ff         <= '0;
         for (int v = 0; v < NUM_VOICES; v++) voice_prio_ff[v] <= psva_pkg::PRIO_NONE;
      end else if (fire) begin
         sample_prio_ff  <= sample_prio_in;
         sample_start_ff <= sample_start_in;
         once_ff         <= once_in;
         voice_prio_ff   <= voice_prio_in;
      end
   end

   // a started play-once leaves its flag set
   `PSVA_ASSERT(a_once_flag_set, clock, reset,
      (fire && item.command == psva_pkg::CMD_ONCE &&
       (result.start_sample || result.start_voice)) |=> |(once_ff & $past(sel)))
   // a sample start records the request time
   `PSVA_ASSERT(a_start_time, clock, reset,
      (fire && result.start_sample) |=> (sample_start_ff == $past(item.now_ms)))
   // stop never starts anything
   `PSVA_ASSERT_NEVER(a_stop_no_start, clock, reset,
      fire && result.stop_all && (result.start_sample || result.start_voice))

endmodule

// File: bench/priority_sound_voice_arbiter_unit_tb.sv
// Self-checking bench for the priority sound voice arbiter: directed, back-pressure and random.
module priority_sound_voice_arbiter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_VOICES    = psva_pkg::NUM_VOICES_DEFAULT;
   localparam int NUM_EFFECTS   = psva_pkg::NUM_EFFECTS_DEFAULT;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 6;        // settle time after the last result is seen
   localparam int CYCLE_LIMIT   = 500_000;
   localparam int MAX_REPORTS   = 10;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 150;
   localparam int LONG_HOLD     = 300;      // receiver hold-off for the back-pressure test
   localparam int WORST_START   = 127;      // start value of the lowest-priority search
   localparam int IDLE_PRIO     = psva_pkg::PRIO_NONE;
   localparam int TABLE_W       = psva_pkg::TABLE_W;
   localparam int HOLD_W        = psva_pkg::HOLD_W;
   localparam logic               MODE_VOICES = ~psva_pkg::MODE_SINGLE;
   localparam logic [TABLE_W-1:0] TABLE_MAX   = {TABLE_W{1'b1}};
   localparam logic [HOLD_W-1:0]  HOLD_MAX    = {HOLD_W{1'b1}};

   typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_style_type;

   // ---------------------------------------------------------------------------------------
   // DUT connections; every input is known from time zero
   // ---------------------------------------------------------------------------------------
   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   psva_pkg::req_type               req       = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   psva_pkg::rsp_type               rsp;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [psva_pkg::CSR_IDX_W-1:0]  csr_index = psva_pkg::CSR_MODE;
   logic [psva_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   priority_sound_voice_arbiter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial forever #2 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Arbitration shadow: its own copy of the registers and of the priority state
   // ---------------------------------------------------------------------------------------
   psva_pkg::cfg_type model_cfg = '{psva_pkg::MODE_RESET, psva_pkg::TABLE_RESET,
                                    psva_pkg::HOLD_RESET};
   int          sample_prio = IDLE_PRIO;
   logic [31:0] sample_start = '0;
   int          voice_prio [NUM_VOICES] = '{default: IDLE_PRIO};
   logic [NUM_EFFECTS-1:0] once_armed = '0;

   psva_pkg::rsp_type expected_starts [$];   // predicted results, oldest first
   logic [31:0] now_tick = '0;            // running millisecond clock for random requests

   // coverage tallies for the closing summary
   int requests_taken   = 0;
   int results_seen     = 0;
   int sample_starts    = 0;
   int refused_in_hold  = 0;
   int voice_starts     = 0;
   int voice_steals     = 0;
   int dropped_no_voice = 0;
   int stop_alls        = 0;
   int errors           = 0;

   // receiver controls
   rx_style_type rx_style      = RX_FREE;
   int           rx_stall_pct  = 0;
   int           rsp_hold_left = 0;

   int unsigned cycle_count = 0;

   // Start effect k on the sample channel or on a voice, or refuse it.
   function automatic psva_pkg::rsp_type start_effect(input logic [2:0] k,
                                                      input psva_pkg::req_type r);
      psva_pkg::rsp_type o;
      int          p;
      int          slot;
      int          worst;
      int          worst_prio;
      logic [31:0] elapsed;
      o = '0;
      p = int'((model_cfg.priority_table >> (psva_pkg::PRIO_W * k)) & 3'h7);
      if (model_cfg.mode_select == psva_pkg::MODE_SINGLE) begin
         // wrapping elapsed time since the playing sample began
         elapsed = r.now_ms - sample_start;
         if (!r.sample_busy) begin
            sample_prio = IDLE_PRIO;
         end else if (p < sample_prio && elapsed < {16'd0, model_cfg.hold_ms}) begin
            refused_in_hold++;
            return o;
         end
         sample_prio     = p;
         sample_start    = r.now_ms;
         o.start_sample  = 1'b1;
         o.effect_id     = k;
         sample_starts++;
      end else begin
         slot       = -1;
         worst      = -1;
         worst_prio = WORST_START;
         for (int v = 0; v < NUM_VOICES; v++) begin
            if (!r.voice_busy[v]) begin
               slot = v;
               break;
            end
            if (voice_prio[v] < worst_prio) begin
               worst_prio = voice_prio[v];
               worst      = v;
            end
         end
         // every voice busy: steal the least important one, strictly lower only
         if (slot < 0 && worst_prio < p) begin
            slot = worst;
            voice_steals++;
         end
         if (slot < 0) begin
            dropped_no_voice++;
            return o;
         end
         voice_prio[slot] = p;
         o.start_voice    = 1'b1;
         o.voice_index    = 2'(slot);
         o.effect_id      = k;
         voice_starts++;
      end
      return o;
   endfunction

   // Result of one accepted request; updates the shadow state.
   function automatic psva_pkg::rsp_type arbitrate(input psva_pkg::req_type r);
      psva_pkg::rsp_type o;
      logic       known;
      logic [2:0] k;
      o     = '0;
      k     = r.sound_id;
      known = (k < NUM_EFFECTS);
      requests_taken++;
      case (r.command)
         psva_pkg::CMD_PLAY: begin
            if (known) o = start_effect(k, r);
         end
         psva_pkg::CMD_ONCE: begin
            // a play-once only goes ahead while its flag is clear
            if (known && !once_armed[k]) begin
               once_armed[k] = 1'b1;
               o = start_effect(k, r);
            end
         end
         psva_pkg::CMD_DONE: begin
            if (known) once_armed[k] = 1'b0;
         end
         default: begin
            // stop all: single channel forgets its sample, voices keep their priorities
            if (model_cfg.mode_select == psva_pkg::MODE_SINGLE) sample_prio = IDLE_PRIO;
            o.stop_all = 1'b1;
            stop_alls++;
         end
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------------
   // Offer one request and hold it until the transfer; valid stays high on return so a
   // back-to-back request needs no second assignment in the same step.
   task automatic send_request(input psva_pkg::req_type item);
      req       <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_starts.push_back(arbitrate(item));
   endtask

   // Stop offering, wait for every predicted result, then let the pipe settle.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_starts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers, one transfer each, valid held high across them.
   task automatic program_csrs(input psva_pkg::cfg_type c);
      logic [psva_pkg::CSR_IDX_W-1:0]  idx [3];
      logic [psva_pkg::CSR_DATA_W-1:0] value [3];
      idx[0]   = psva_pkg::CSR_MODE;
      idx[1]   = psva_pkg::CSR_TABLE;
      idx[2]   = psva_pkg::CSR_HOLD;
      value[0] = psva_pkg::CSR_DATA_W'(c.mode_select);
      value[1] = psva_pkg::CSR_DATA_W'(c.priority_table);
      value[2] = psva_pkg::CSR_DATA_W'(c.hold_ms);
      for (int i = 0; i < 3; i++) begin
         csr_index <= idx[i];
         csr_data  <= value[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      model_cfg = c;
   endtask

   function automatic psva_pkg::req_type make_req(input logic [1:0] cmd, input logic [2:0] id,
                                                  input logic [31:0] now,
                                                  input logic [2:0] vbusy,
                                                  input logic sbusy);
      return '{command: cmd, sound_id: id, now_ms: now, voice_busy: vbusy, sample_busy: sbusy};
   endfunction

   // Random request; time mostly creeps forward so the hold window matters,
   // sometimes lands right on its edge, sometimes jumps anywhere (wrap included).
   function automatic psva_pkg::req_type random_request();
      psva_pkg::req_type r;
      int unsigned pick;
      pick      = $urandom_range(0, 99);
      r.command = (pick < 45) ? psva_pkg::CMD_PLAY : (pick < 70) ? psva_pkg::CMD_ONCE :
                  (pick < 88) ? psva_pkg::CMD_DONE : psva_pkg::CMD_STOP;
      r.sound_id = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, NUM_EFFECTS - 1));
      case ($urandom_range(0, 9))
         0:       now_tick = $urandom;
         1:       now_tick = sample_start + 32'(model_cfg.hold_ms)
                             + 32'($urandom_range(0, 2)) - 32'd1;
         2:       now_tick = now_tick + 32'($urandom_range(0, 2000));
         default: now_tick = now_tick + 32'($urandom_range(0, 60));
      endcase
      r.now_ms      = now_tick;
      r.voice_busy  = ($urandom_range(0, 4) < 3) ? 3'b111 : 3'($urandom_range(0, 7));
      r.sample_busy = ($urandom_range(0, 7) != 0);
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Receiver: long hold-off when asked, otherwise free, random or patterned stalls
   // ---------------------------------------------------------------------------------------
   initial begin : receiver
      logic [15:0] rx_pattern;
      int          pattern_age;
      rx_pattern  = 16'hA6C3;
      pattern_age = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            case (rx_style)
               RX_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
               RX_PATTERN: begin
                  rsp_stall  <= rx_pattern[0];
                  rx_pattern  = {rx_pattern[0], rx_pattern[15:1]};
                  pattern_age++;
                  if (pattern_age == 64) begin
                     rx_pattern  = 16'($urandom);
                     pattern_age = 0;
                  end
               end
               default:    rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result checker: every transfer against the oldest prediction
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      psva_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_starts.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"mismatch: result with nothing expected: ",
                         "ss=%b sv=%b vi=%0d id=%0d stop=%b"},
                        rsp.start_sample, rsp.start_voice, rsp.voice_index, rsp.effect_id,
                        rsp.stop_all);
         end else begin
            want = expected_starts.pop_front();
            if (rsp.start_sample !== want.start_sample || rsp.start_voice !== want.start_voice ||
                rsp.voice_index !== want.voice_index || rsp.effect_id !== want.effect_id ||
                rsp.stop_all !== want.stop_all) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display({"mismatch: result %0d expected ss=%b sv=%b vi=%0d id=%0d stop=%b, ",
                            "got ss=%b sv=%b vi=%0d id=%0d stop=%b"},
                           results_seen, want.start_sample, want.start_voice, want.voice_index,
                           want.effect_id, want.stop_all, rsp.start_sample, rsp.start_voice,
                           rsp.voice_index, rsp.effect_id, rsp.stop_all);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------
   // Voice mode at reset values: idle voice first, stealing from never-assigned voices
   // (priority -1), strict-lower stealing, refused steal, play-once guard, bad ids, stop.
   task automatic test_voice_defaults();
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd0, 32'd0,         3'b000, 1'b0));
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd4, 32'hFFFF_FFFF, 3'b111, 1'b1));
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'd5,         3'b111, 1'b1));
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd6, 32'd6,         3'b111, 1'b0));
      // lower priority than every voice: dropped
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'd7,         3'b111, 1'b1));
      send_request(make_req(psva_pkg::CMD_ONCE, 3'd3, 32'd8,         3'b011, 1'b1));
      // flag set: nothing
      send_request(make_req(psva_pkg::CMD_ONCE, 3'd3, 32'd9,         3'b000, 1'b1));
      send_request(make_req(psva_pkg::CMD_DONE, 3'd3, 32'd10,        3'b000, 1'b1));
      send_request(make_req(psva_pkg::CMD_ONCE, 3'd3, 32'd11,        3'b000, 1'b1));
      // out of range
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd7, 32'd12,        3'b000, 1'b0));
      send_request(make_req(psva_pkg::CMD_ONCE, 3'd7, 32'd13,        3'b000, 1'b0));
      send_request(make_req(psva_pkg::CMD_DONE, 3'd7, 32'd14,        3'b101, 1'b1));
      send_request(make_req(psva_pkg::CMD_STOP, 3'd5, 32'd15,        3'b111, 1'b1));
      wait_results_drained();
   endtask

   // Single channel: idle start, higher priority replaces, hold window just inside and
   // just at its end, equal priority, elapsed time across the 32-bit wrap, stop clearing.
   task automatic test_single_channel();
      program_csrs('{psva_pkg::MODE_SINGLE, psva_pkg::TABLE_RESET, psva_pkg::HOLD_RESET});
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'd1000,      3'b000, 1'b0));
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd0, 32'd1010,      3'b000, 1'b1));
      // inside hold
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'd1309,      3'b000, 1'b1));
      // hold over
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'd1310,      3'b000, 1'b1));
      // equal priority
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'd1311,      3'b000, 1'b1));
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd4, 32'hFFFF_FF00, 3'b000, 1'b1));
      // wrapped, held
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'h0000_0010, 3'b000, 1'b1));
      send_request(make_req(psva_pkg::CMD_STOP, 3'd0, 32'h0000_0011, 3'b000, 1'b1));
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'h0000_0020, 3'b000, 1'b1));
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd4, 32'h0000_0021, 3'b000, 1'b1));
      // channel idle
      send_request(make_req(psva_pkg::CMD_PLAY, 3'd2, 32'h0000_0022, 3'b000, 1'b0));
      wait_results_drained();
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the block
   // fills and stalls its input; then the sender waits for every result.
   task automatic test_backpressure();
      rx_style      = RX_FREE;
      rsp_hold_left = LONG_HOLD;
      for (int n = 0; n < 40; n++) send_request(random_request());
      wait_results_drained();
   endtask

   // Random traffic over several register settings, extremes included, with bursty
   // sending and a receiver style that rotates from phase to phase.
   task automatic test_random_phases();
      psva_pkg::cfg_type c;
      int      burst_left;
      int      gap;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       c = '{psva_pkg::MODE_SINGLE, TABLE_W'($urandom_range(0, 2097151)),
                           psva_pkg::HOLD_RESET};
            1:       c = '{MODE_VOICES, TABLE_W'($urandom_range(0, 2097151)), HOLD_W'($urandom)};
            2:       c = '{psva_pkg::MODE_SINGLE, {TABLE_W{1'b0}}, {HOLD_W{1'b0}}};
            3:       c = '{psva_pkg::MODE_SINGLE, TABLE_MAX, HOLD_MAX};
            4:       c = '{MODE_VOICES, TABLE_MAX, HOLD_W'($urandom)};
            5:       c = '{MODE_VOICES, {TABLE_W{1'b0}}, psva_pkg::HOLD_RESET};
            6:       c = '{psva_pkg::MODE_SINGLE, TABLE_W'($urandom_range(0, 2097151)),
                           HOLD_W'($urandom_range(0, 100))};
            default: c = '{MODE_VOICES, TABLE_W'($urandom_range(0, 2097151)),
                           HOLD_W'($urandom_range(0, 100))};
         endcase
         program_csrs(c);
         rx_style     = (phase % 3 == 0) ? RX_FREE : (phase % 3 == 1) ? RX_RANDOM : RX_PATTERN;
         rx_stall_pct = $urandom_range(10, 60);
         burst_left   = $urandom_range(1, 24);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            send_request(random_request());
            burst_left--;
         end
         wait_results_drained();
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin : main
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_voice_defaults();
      test_single_channel();
      test_backpressure();
      test_random_phases();

      rx_style = RX_FREE;
      wait_results_drained();
      errors += expected_starts.size();

      $display({"summary: %0d requests, %0d results; sample starts %0d (refused in hold %0d), ",
                "voice starts %0d (steals %0d, dropped %0d)"},
               requests_taken, results_seen, sample_starts, refused_in_hold, voice_starts,
               voice_steals, dropped_no_voice);
      $display("summary: %0d stop-all, both modes over %0d register settings, %0d mismatches",
               stop_alls, PHASES + 2, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/psva_pkg.sv
design/psva_csr.sv
design/psva_engine.sv
design/priority_sound_voice_arbiter_unit.sv
bench/priority_sound_voice_arbiter_unit_tb.sv
